/* rtl/stereo_rms_noise_gate_core_defines.svh */
// assertion helpers shared by the gate rtl
`ifndef STEREO_RMS_NOISE_GATE_CORE_DEFINES_SVH
`define STEREO_RMS_NOISE_GATE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRNG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srng check failed");

// next-cycle implication, disabled while in reset
`define SRNG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srng check failed");

`endif

/* rtl/srng_pkg.sv */
package srng_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 24;
    localparam int COEF_MAX_BITS   = 32;
    localparam int ENV_BITS        = 32;
    localparam int GAIN_BITS       = 24;
    localparam int GAIN_FRAC       = 23;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 24'd8388608;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS          = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_MODE       = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DETECTOR_SOURCE = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RMS_COEF        = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_COEF      = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD_SQ    = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR_REDUCTION = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR_MUTE      = 4'd7;

    localparam logic [23:0]          RMS_COEF_RESET        = 24'd16707555;
    localparam logic [23:0]          DECAY_COEF_RESET      = 24'd16773720;
    localparam logic [ENV_BITS-1:0]  THRESHOLD_SQ_RESET    = 32'd21474;
    localparam logic [GAIN_BITS-1:0] FLOOR_REDUCTION_RESET = 24'd838861;
    localparam logic [GAIN_BITS-1:0] FLOOR_MUTE_RESET      = 24'd8;

    typedef struct packed {
        logic                     bypass;
        logic                     gate_mode;
        logic                     detector_source;
        logic [COEF_MAX_BITS-1:0] rms_coef;
        logic [COEF_MAX_BITS-1:0] decay_coef;
        logic [ENV_BITS-1:0]      threshold_sq;
        logic [GAIN_BITS-1:0]     floor_reduction;
        logic [GAIN_BITS-1:0]     floor_mute;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    typedef enum logic [3:0] {
        LS_IDLE,
        LS_SQ_MUL,
        LS_SQ_RND,
        LS_ENV_MUL,
        LS_ENV_SUM,
        LS_TARGET,
        LS_GAIN_MUL,
        LS_GAIN_SUM,
        LS_OUT_MUL,
        LS_OUT_SAT,
        LS_DONE
    } t_lane_step;

endpackage

/* rtl/srng_frame_if.sv */
interface srng_frame_if
    import srng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] audio_left;
    logic signed [SAMPLE_BITS-1:0] audio_right;
    logic signed [SAMPLE_BITS-1:0] side_left;
    logic signed [SAMPLE_BITS-1:0] side_right;
    logic                          side_present;
    logic                          side_mono;

    modport source (
        output valid, audio_left, audio_right, side_left, side_right, side_present, side_mono,
        input  ready
    );
    modport sink (
        input  valid, audio_left, audio_right, side_left, side_right, side_present, side_mono,
        output ready
    );
endinterface

/* rtl/srng_out_if.sv */
interface srng_out_if
    import srng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink (input valid, out_left, out_right, output ready);
endinterface

/* rtl/srng_cfg_if.sv */
interface srng_cfg_if
    import srng_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/srng_regs.sv */
module srng_regs
    import srng_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srng_cfg_if.sink         i_cfg,
    output t_cfg             o_cfg
);
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bypass          <= 1'b0;
            r_cfg.gate_mode       <= 1'b0;
            r_cfg.detector_source <= 1'b1;
            r_cfg.rms_coef        <= COEF_MAX_BITS'(COEF_BITS'(RMS_COEF_RESET));
            r_cfg.decay_coef      <= COEF_MAX_BITS'(COEF_BITS'(DECAY_COEF_RESET));
            r_cfg.threshold_sq    <= THRESHOLD_SQ_RESET;
            r_cfg.floor_reduction <= FLOOR_REDUCTION_RESET;
            r_cfg.floor_mute      <= FLOOR_MUTE_RESET;
        end else if (i_cfg.valid) begin
            // writes to unknown indexes are dropped
            unique case (i_cfg.index)
                CFG_BYPASS:          r_cfg.bypass <= i_cfg.data[0];
                CFG_GATE_MODE:       r_cfg.gate_mode <= i_cfg.data[0];
                CFG_DETECTOR_SOURCE: r_cfg.detector_source <= i_cfg.data[0];
                CFG_RMS_COEF: begin
                    r_cfg.rms_coef <= COEF_MAX_BITS'(COEF_BITS'(i_cfg.data[23:0]));
                end
                CFG_DECAY_COEF: begin
                    r_cfg.decay_coef <= COEF_MAX_BITS'(COEF_BITS'(i_cfg.data[23:0]));
                end
                CFG_THRESHOLD_SQ:    r_cfg.threshold_sq <= i_cfg.data[ENV_BITS-1:0];
                CFG_FLOOR_REDUCTION: r_cfg.floor_reduction <= i_cfg.data[GAIN_BITS-1:0];
                CFG_FLOOR_MUTE:      r_cfg.floor_mute <= i_cfg.data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end
endmodule

/* rtl/srng_lane.sv */
`include "stereo_rms_noise_gate_core_defines.svh"

module srng_lane
    import srng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_det,
    input  logic signed [SAMPLE_BITS-1:0] i_aud,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    // square of a full-scale sample lands in Q1.31
    localparam int SQ_FB  = 2 * SAMPLE_BITS - 2;
    localparam int SQ_RSH = (SQ_FB > ENV_BITS - 1) ? SQ_FB - (ENV_BITS - 1) : 0;
    localparam int SQ_LSH = (SQ_FB > ENV_BITS - 1) ? 0 : (ENV_BITS - 1) - SQ_FB;
    localparam int SQW    = 2 * SAMPLE_BITS + 1;
    localparam logic [63:0] SQ_RND = (64'd1 << SQ_RSH) >> 1;

    localparam int EPW = COEF_BITS + ENV_BITS + 2;
    localparam int GPW = COEF_BITS + GAIN_BITS + 2;
    localparam int OPW = SAMPLE_BITS + GAIN_BITS + 1;

    localparam logic [EPW-1:0] ENV_HALF  = EPW'(1) << (COEF_BITS - 1);
    localparam logic [GPW-1:0] GAIN_HALF = GPW'(1) << (COEF_BITS - 1);
    localparam logic [OPW-1:0] OUT_HALF  = OPW'(1) << (GAIN_FRAC - 1);
    localparam logic signed [OPW-1:0] S_HI =
        OPW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [OPW-1:0] S_LO = -S_HI - OPW'(1);

    t_lane_step r_step, n_step;

    logic signed [SAMPLE_BITS-1:0] r_det, r_aud, r_out, n_out;
    logic [2*SAMPLE_BITS-1:0]      r_sq_raw, n_sq_raw;
    logic [ENV_BITS-1:0]           r_sq, n_sq, r_env, n_env;
    logic signed [EPW-1:0]         r_env_prod, n_env_prod, env_sum;
    logic signed [ENV_BITS:0]      env_diff;
    logic [GAIN_BITS-1:0]          r_tgt, n_tgt, r_gain, n_gain, floor_sel, floor_lim;
    logic signed [GPW-1:0]         r_gain_prod, n_gain_prod, gain_sum;
    logic signed [GAIN_BITS:0]     gain_diff;
    logic signed [OPW-1:0]         r_out_prod, n_out_prod, out_round, out_q;
    logic [SAMPLE_BITS-1:0]        det_mag;
    logic [COEF_BITS-1:0]          coef_a, coef_d;

    assign coef_a   = i_cfg.rms_coef[COEF_BITS-1:0];
    assign coef_d   = i_cfg.decay_coef[COEF_BITS-1:0];
    assign o_done   = (r_step == LS_DONE);
    assign o_sample = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= LS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            LS_IDLE:     if (i_ctl.start) n_step = LS_SQ_MUL;
            LS_SQ_MUL:   n_step = LS_SQ_RND;
            LS_SQ_RND:   n_step = LS_ENV_MUL;
            LS_ENV_MUL:  n_step = LS_ENV_SUM;
            LS_ENV_SUM:  n_step = LS_TARGET;
            LS_TARGET:   n_step = LS_GAIN_MUL;
            LS_GAIN_MUL: n_step = LS_GAIN_SUM;
            LS_GAIN_SUM: n_step = LS_OUT_MUL;
            LS_OUT_MUL:  n_step = LS_OUT_SAT;
            LS_OUT_SAT:  n_step = LS_DONE;
            LS_DONE:     if (i_ctl.take) n_step = LS_IDLE;
            default:     n_step = LS_IDLE;
        endcase
    end

    always_comb begin
        // magnitude of the most negative sample still fits unsigned
        det_mag  = r_det[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_det) : SAMPLE_BITS'(r_det);
        n_sq_raw = (2*SAMPLE_BITS)'(det_mag) * (2*SAMPLE_BITS)'(det_mag);
        n_sq     = ENV_BITS'(((SQW'(r_sq_raw) + SQW'(SQ_RND)) >> SQ_RSH) << SQ_LSH);

        // a*env + (1-a)*sq folded into a*(env-sq) + sq
        env_diff   = $signed({1'b0, r_env}) - $signed({1'b0, r_sq});
        n_env_prod = $signed({1'b0, coef_a}) * env_diff;
        env_sum    = r_env_prod + $signed(EPW'(r_sq) << COEF_BITS) + $signed(ENV_HALF);
        n_env      = env_sum[COEF_BITS +: ENV_BITS];

        floor_sel = i_cfg.gate_mode ? i_cfg.floor_mute : i_cfg.floor_reduction;
        floor_lim = (floor_sel > GAIN_UNITY) ? GAIN_UNITY : floor_sel;
        n_tgt     = (r_env >= i_cfg.threshold_sq) ? GAIN_UNITY : floor_lim;

        gain_diff   = $signed({1'b0, r_gain}) - $signed({1'b0, r_tgt});
        n_gain_prod = $signed({1'b0, coef_d}) * gain_diff;
        gain_sum    = r_gain_prod + $signed(GPW'(r_tgt) << COEF_BITS) + $signed(GAIN_HALF);
        n_gain      = gain_sum[COEF_BITS +: GAIN_BITS];

        n_out_prod = $signed(r_aud) * $signed({1'b0, r_gain});
        out_round  = r_out_prod + $signed(OUT_HALF);
        out_q      = out_round >>> GAIN_FRAC;
        if (i_cfg.bypass) begin
            n_out = r_aud;
        end else if (out_q > S_HI) begin
            n_out = SAMPLE_BITS'(S_HI);
        end else if (out_q < S_LO) begin
            n_out = SAMPLE_BITS'(S_LO);
        end else begin
            n_out = SAMPLE_BITS'(out_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == LS_IDLE && i_ctl.start) begin
            r_det <= i_det;
            r_aud <= i_aud;
        end
        if (r_step == LS_SQ_MUL)   r_sq_raw <= n_sq_raw;
        if (r_step == LS_SQ_RND)   r_sq <= n_sq;
        if (r_step == LS_ENV_MUL)  r_env_prod <= n_env_prod;
        if (r_step == LS_TARGET)   r_tgt <= n_tgt;
        if (r_step == LS_GAIN_MUL) r_gain_prod <= n_gain_prod;
        if (r_step == LS_OUT_MUL)  r_out_prod <= n_out_prod;
        if (r_step == LS_OUT_SAT)  r_out <= n_out;
    end

    // detector and gain state, frozen in bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_gain <= GAIN_UNITY;
        end else begin
            if (r_step == LS_ENV_SUM && !i_cfg.bypass) r_env <= n_env;
            if (r_step == LS_GAIN_SUM && !i_cfg.bypass) r_gain <= n_gain;
        end
    end

    `SRNG_ASSERT_IMP(a_start_only_idle, i_clk, i_rst_n, i_ctl.start, r_step == LS_IDLE)
    `SRNG_ASSERT_NEXT(a_bypass_holds_env, i_clk, i_rst_n, i_cfg.bypass && r_step == LS_ENV_SUM, $stable(r_env))
    `SRNG_ASSERT_IMP(a_gain_at_most_unity, i_clk, i_rst_n, 1'b1, r_gain <= GAIN_UNITY)
endmodule

/* rtl/srng_merge.sv */
module srng_merge
    import srng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_done,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_take,
    srng_out_if.source                    o_frame
);
    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_left, r_right;

    // both lanes finished and the output word is free or leaving
    assign o_take = (&i_done) && (!r_valid || o_frame.ready);

    assign o_frame.valid     = r_valid;
    assign o_frame.out_left  = r_left;
    assign o_frame.out_right = r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_left  <= i_left;
            r_right <= i_right;
        end
    end
endmodule

/* rtl/stereo_rms_noise_gate_core.sv */
// Stereo noise gate: each input word is one stereo frame (audio plus optional sidechain) and
// yields one gated output word. Left and right run in two identical lanes, each a nine-step
// sequence (square, envelope multiply and sum, gate target, gain multiply and sum, output
// multiply and saturate) with one multiplier step per cycle; a new frame is accepted only after
// both lanes have handed the last one to the output register, which waits while the output stalls.
// A finished frame sits in the output register while the next one is already processed.
// Configuration writes are taken at any time but must only be issued while no frame is in flight.
`include "stereo_rms_noise_gate_core_defines.svh"

module stereo_rms_noise_gate_core
    import srng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srng_frame_if.sink i_frame,
    srng_out_if.source o_frame,
    srng_cfg_if.sink   i_cfg
);
    t_cfg      cfg;
    t_lane_ctl lane_ctl;
    logic      r_busy;
    logic      accept, take, use_side;
    logic [1:0] done;
    logic signed [SAMPLE_BITS-1:0] det_left, det_right, lane_left, lane_right;

    srng_regs #(.COEF_BITS(COEF_BITS)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign i_frame.ready = !r_busy;
    assign accept        = i_frame.valid && !r_busy;

    // external detector only when a sidechain is wired; mono feeds both lanes
    assign use_side  = cfg.detector_source && i_frame.side_present;
    assign det_left  = use_side ? i_frame.side_left : i_frame.audio_left;
    assign det_right = !use_side ? i_frame.audio_right :
                       (i_frame.side_mono ? i_frame.side_left : i_frame.side_right);

    assign lane_ctl.start = accept;
    assign lane_ctl.take  = take;

    srng_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_ctl    (lane_ctl),
        .i_det    (det_left),
        .i_aud    (i_frame.audio_left),
        .o_done   (done[0]),
        .o_sample (lane_left)
    );

    srng_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_ctl    (lane_ctl),
        .i_det    (det_right),
        .i_aud    (i_frame.audio_right),
        .o_done   (done[1]),
        .o_sample (lane_right)
    );

    srng_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (done),
        .i_left  (lane_left),
        .i_right (lane_right),
        .o_take  (take),
        .o_frame (o_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (take) begin
            r_busy <= 1'b0;
        end
    end

    `SRNG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_frame.ready)
    `SRNG_ASSERT_IMP(a_lanes_lockstep, i_clk, i_rst_n, 1'b1, done[0] == done[1])
    `SRNG_ASSERT_NEXT(a_take_fills_output, i_clk, i_rst_n, take, o_frame.valid)
endmodule
